// ===== rtl/core/tbor_pkg.sv =====
// Shared widths, constants and divider handshake types for the touch
// baseline outlier removal block. Used by the top level and the divider.
`timescale 1ns / 1ps

package tbor_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int VAL_W     = 16;
  localparam int SUM_W     = 24;
  localparam int DIV_W     = SUM_W;
  localparam int DVSR_W    = 2 * CNT_W;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/tbor_div.sv =====
// Shared sequential divider: signed dividend over a positive divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// Depends on tbor_pkg for widths and the request and response types.
`timescale 1ns / 1ps

module tbor_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbor_pkg::div_req_t req_i,
  output tbor_pkg::div_rsp_t rsp_o
);

  localparam int DIV_W  = tbor_pkg::DIV_W;
  localparam int DVSR_W = tbor_pkg::DVSR_W;
  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [DIV_W-1:0]  mag_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVSR_W-1:0] rem_q;
  logic [DVSR_W-1:0] dvsr_q;
  logic [DIV_W-1:0]  res_q;

  logic [DIV_W-1:0]  abs_in;
  logic [DVSR_W:0]   rem_sh;
  logic              fits;
  logic [DVSR_W-1:0] rem_nx;
  logic [DIV_W-1:0]  quo_nx;

  always_comb begin
    abs_in = req_i.dividend[DIV_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
    rem_sh = {rem_q, mag_q[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvsr_q};
    rem_nx = fits ? DVSR_W'(rem_sh - {1'b0, dvsr_q}) : rem_sh[DVSR_W-1:0];
    quo_nx = {quo_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvsr_q <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
        neg_q  <= req_i.dividend[DIV_W-1];
        mag_q  <= abs_in;
        quo_q  <= '0;
        rem_q  <= '0;
        dvsr_q <= req_i.divisor;
      end else if (busy_q) begin
        mag_q  <= {mag_q[DIV_W-2:0], 1'b0};
        rem_q  <= rem_nx;
        quo_q  <= quo_nx;
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= neg_q ? (~quo_nx + 1'b1) : quo_nx;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

// ===== rtl/core/touch_baseline_outlier_removal.sv =====
// Top level of the touch baseline outlier removal block: node store,
// frame sequencer, configuration registers and output register.
// Depends on tbor_pkg and tbor_div.
`timescale 1ns / 1ps

// Samples are taken one per cycle until the transfer that carries frame_end.
// The frame is then processed with the input stalled. All divisions share one
// divider. With n stored nodes, b baseline nodes and p of them pulled down,
// processing averages the b baseline nodes, checks each of the n nodes, divides
// twice for each of the p pulled nodes, averages again and then gives one result
// per node while the output is not stalled. Without baseline nodes both averaging
// divisions are skipped. Up to MAX_NODES samples are kept; later ones are dropped.
module touch_baseline_outlier_removal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] corrected_o,
  output logic        replaced_o,
  output logic        result_last_o
);

  localparam int MAX_NODES = tbor_pkg::MAX_NODES;
  localparam int IDX_W     = tbor_pkg::IDX_W;
  localparam int CNT_W     = tbor_pkg::CNT_W;
  localparam int VAL_W     = tbor_pkg::VAL_W;
  localparam int SUM_W     = tbor_pkg::SUM_W;
  localparam int DIV_W     = tbor_pkg::DIV_W;
  localparam int DVSR_W    = tbor_pkg::DVSR_W;

  localparam logic REG_THR  = 1'b0;
  localparam logic REG_BAND = 1'b1;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_AVG1 = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_CHK1 = 4'd3;
  localparam logic [3:0] S_DIVA = 4'd4;
  localparam logic [3:0] S_DIVB = 4'd5;
  localparam logic [3:0] S_AVG2 = 4'd6;
  localparam logic [3:0] S_ORD  = 4'd7;
  localparam logic [3:0] S_OWR  = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [15:0]             thr_q, thr_d;
  logic [14:0]             band_q, band_d;
  logic [CNT_W-1:0]        node_cnt_q, node_cnt_d;
  logic [CNT_W-1:0]        band_cnt_q, band_cnt_d;
  logic [SUM_W-1:0]        band_sum_q, band_sum_d;
  logic [SUM_W-1:0]        sum2_q, sum2_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [VAL_W-1:0]        avg_q, avg_d;
  logic [VAL_W-1:0]        avg2_q, avg2_d;
  logic [DIV_W-1:0]        q1_q, q1_d;
  logic [16:0]             exc_q, exc_d;
  logic [DVSR_W-1:0]       cnt_sq_q, cnt_sq_d;
  logic                    out_valid_q, out_valid_d;
  logic [VAL_W-1:0]        out_val_q, out_val_d;
  logic                    out_rep_q, out_rep_d;
  logic                    out_last_q, out_last_d;

  logic [VAL_W:0]          mem_q [MAX_NODES];
  logic [VAL_W:0]          rd_q;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [VAL_W:0]          wr_data;

  tbor_pkg::div_req_t      div_req;
  tbor_pkg::div_rsp_t      div_rsp;

  logic                    cfg_wr;
  logic                    in_acc;
  logic                    store_ok;
  logic                    is_base;
  logic [16:0]             s17, lim17;
  logic [CNT_W-1:0]        nc_nx, bc_nx;
  logic [SUM_W-1:0]        bs_nx;
  logic [VAL_W-1:0]        rd_val;
  logic                    rd_mark;
  logic [16:0]             exc_now;
  logic                    pull;
  logic [19:0]             new_full;
  logic [VAL_W-1:0]        new_sat;
  logic [SUM_W-1:0]        sum2_add;
  logic                    last_node;
  logic                    out_load;
  logic [DVSR_W-1:0]       cnt_ext;

  tbor_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BAND) ? {17'b0, band_q} : {{16{thr_q[15]}}, thr_q};

  always_comb begin
    thr_d  = thr_q;
    band_d = band_q;
    if (cfg_wr) begin
      if (paddr[2] == REG_THR) begin
        thr_d = pwdata[15:0];
      end else begin
        band_d = pwdata[14:0];
      end
    end
  end

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_ok   = node_cnt_q < CNT_W'(MAX_NODES);
  assign s17        = {sample_i[15], sample_i};
  assign lim17      = {2'b00, band_q};
  assign is_base    = ($signed(s17) <= $signed(lim17)) && ($signed(s17) >= -$signed(lim17));
  assign nc_nx      = node_cnt_q + CNT_W'(store_ok);
  assign bc_nx      = band_cnt_q + CNT_W'(store_ok && is_base);
  assign bs_nx      = (store_ok && is_base) ?
                      band_sum_q + {{(SUM_W-VAL_W){sample_i[15]}}, sample_i} : band_sum_q;

  assign rd_val    = rd_q[VAL_W-1:0];
  assign rd_mark   = rd_q[VAL_W];
  assign exc_now   = {rd_val[15], rd_val} - {avg_q[15], avg_q};
  assign pull      = $signed(exc_now) >= $signed({thr_q[15], thr_q});
  assign new_full  = {{4{avg_q[15]}}, avg_q} - q1_q[19:0] - div_rsp.quotient[19:0];
  assign last_node = (idx_q + 1'b1) == node_cnt_q;
  assign cnt_ext   = {{(DVSR_W-CNT_W){1'b0}}, band_cnt_q};
  assign out_load  = (state_q == S_OWR) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if ($signed(new_full) > 20'sd32767) begin
      new_sat = 16'h7FFF;
    end else if ($signed(new_full) < -20'sd32768) begin
      new_sat = 16'h8000;
    end else begin
      new_sat = new_full[15:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    node_cnt_d  = node_cnt_q;
    band_cnt_d  = band_cnt_q;
    band_sum_d  = band_sum_q;
    sum2_d      = sum2_q;
    idx_d       = idx_q;
    avg_d       = avg_q;
    avg2_d      = avg2_q;
    q1_d        = q1_q;
    exc_d       = exc_q;
    cnt_sq_d    = cnt_sq_q;
    out_val_d   = out_val_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    out_valid_d = (out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = node_cnt_q[IDX_W-1:0];
    wr_data     = {!is_base, sample_i};
    sum2_add    = sum2_q;
    div_req     = '0;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          wr_en      = store_ok;
          node_cnt_d = nc_nx;
          band_cnt_d = bc_nx;
          band_sum_d = bs_nx;
          idx_d      = '0;
          sum2_d     = '0;
          if (frame_end_i) begin
            if (bc_nx != '0) begin
              div_req.start    = 1'b1;
              div_req.dividend = bs_nx;
              div_req.divisor  = {{(DVSR_W-CNT_W){1'b0}}, bc_nx};
              state_d          = S_AVG1;
            end else begin
              state_d = S_ORD;
            end
          end
        end
      end
      S_AVG1: begin
        if (div_rsp.done) begin
          avg_d    = div_rsp.quotient[VAL_W-1:0];
          cnt_sq_d = cnt_ext * cnt_ext;
          state_d  = S_RD1;
        end
      end
      S_RD1: begin
        state_d = S_CHK1;
      end
      S_CHK1: begin
        if (!rd_mark && pull) begin
          exc_d            = exc_now;
          div_req.start    = 1'b1;
          div_req.dividend = {{(DIV_W-17){exc_now[16]}}, exc_now};
          div_req.divisor  = cnt_ext;
          state_d          = S_DIVA;
        end else begin
          if (!rd_mark) begin
            sum2_add = sum2_q + {{(SUM_W-VAL_W){rd_val[15]}}, rd_val};
          end
          sum2_d = sum2_add;
          if (last_node) begin
            div_req.start    = 1'b1;
            div_req.dividend = sum2_add;
            div_req.divisor  = cnt_ext;
            state_d          = S_AVG2;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD1;
          end
        end
      end
      S_DIVA: begin
        if (div_rsp.done) begin
          q1_d             = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = {{(DIV_W-17){exc_q[16]}}, exc_q};
          div_req.divisor  = cnt_sq_q;
          state_d          = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_rsp.done) begin
          wr_en    = 1'b1;
          wr_addr  = idx_q[IDX_W-1:0];
          wr_data  = {1'b0, new_sat};
          sum2_add = sum2_q + {{(SUM_W-VAL_W){new_sat[15]}}, new_sat};
          sum2_d   = sum2_add;
          if (last_node) begin
            div_req.start    = 1'b1;
            div_req.dividend = sum2_add;
            div_req.divisor  = cnt_ext;
            state_d          = S_AVG2;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD1;
          end
        end
      end
      S_AVG2: begin
        if (div_rsp.done) begin
          avg2_d  = div_rsp.quotient[VAL_W-1:0];
          idx_d   = '0;
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        state_d = S_OWR;
      end
      S_OWR: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_rep_d   = rd_mark && (band_cnt_q != '0);
          out_val_d   = (rd_mark && (band_cnt_q != '0)) ? avg2_q : rd_val;
          out_last_d  = last_node;
          if (last_node) begin
            node_cnt_d = '0;
            band_cnt_d = '0;
            band_sum_d = '0;
            idx_d      = '0;
            state_d    = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      thr_q       <= 16'd500;
      band_q      <= 15'd360;
      node_cnt_q  <= '0;
      band_cnt_q  <= '0;
      band_sum_q  <= '0;
      sum2_q      <= '0;
      idx_q       <= '0;
      avg_q       <= '0;
      avg2_q      <= '0;
      q1_q        <= '0;
      exc_q       <= '0;
      cnt_sq_q    <= '0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_rep_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      band_q      <= band_d;
      node_cnt_q  <= node_cnt_d;
      band_cnt_q  <= band_cnt_d;
      band_sum_q  <= band_sum_d;
      sum2_q      <= sum2_d;
      idx_q       <= idx_d;
      avg_q       <= avg_d;
      avg2_q      <= avg2_d;
      q1_q        <= q1_d;
      exc_q       <= exc_d;
      cnt_sq_q    <= cnt_sq_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_rep_q   <= out_rep_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign corrected_o   = out_val_q;
  assign replaced_o    = out_rep_q;
  assign result_last_o = out_last_q;

endmodule
